// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/edpq_pkg.sv -----
package edpq_pkg;

    localparam int BYTE_W    = 24;
    localparam int SIZE_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int OCC_PKT_W = 7;
    localparam int DPKT_W    = 32;
    localparam int DBYTE_W   = 48;
    localparam int CFG_IDX_W = 8;

    localparam logic [BYTE_W-1:0] MAX_BYTES_RST = 24'd65536;
    localparam logic [BYTE_W-1:0] DROP_THR_RST  = 24'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_THRESHOLD = 8'd1;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_DEPART  = 1'b1;

    typedef enum logic [1:0] {
        CAUSE_NONE       = 2'd0,
        CAUSE_BYTE_LIMIT = 2'd1,
        CAUSE_EARLY      = 2'd2,
        CAUSE_SLOTS_FULL = 2'd3
    } drop_cause_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_DEC
    } edpq_state_t;

    typedef struct packed {
        logic                req_type;
        logic [SIZE_W-1:0]   pkt_size;
        logic [SAMPLE_W-1:0] rand_sample;
    } edpq_in_t;

    typedef struct packed {
        logic                 admitted;
        logic [1:0]           drop_cause;
        logic                 departed_valid;
        logic [SIZE_W-1:0]    departed_size;
        logic                 empty_error;
        logic [BYTE_W-1:0]    occupancy_bytes;
        logic [OCC_PKT_W-1:0] occupancy_pkts;
        logic [DPKT_W-1:0]    total_dropped_pkts;
        logic [DBYTE_W-1:0]   total_dropped_bytes;
    } edpq_out_t;

    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] size;
    } drop_evt_t;

    typedef struct packed {
        logic [DPKT_W-1:0]  pkts;
        logic [DBYTE_W-1:0] bytes;
    } drop_totals_t;

endpackage

// ----- rtl/edpq_drop_stats.sv -----
module edpq_drop_stats
    import edpq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  drop_evt_t    drop_evt,
    output drop_totals_t totals_next
);

    logic [DPKT_W-1:0]  pkts_reg;
    logic [DBYTE_W-1:0] bytes_reg;
    logic [DBYTE_W:0]   byte_sum;

    always_comb begin
        byte_sum = {1'b0, bytes_reg} + (DBYTE_W+1)'(drop_evt.size);
        totals_next.pkts  = pkts_reg;
        totals_next.bytes = bytes_reg;
        if (drop_evt.valid) begin
            // both totals stick at all-ones
            totals_next.pkts  = (&pkts_reg) ? pkts_reg : pkts_reg + 1'b1;
            totals_next.bytes = byte_sum[DBYTE_W] ? '1 : byte_sum[DBYTE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkts_reg  <= '0;
            bytes_reg <= '0;
        end else begin
            pkts_reg  <= totals_next.pkts;
            bytes_reg <= totals_next.bytes;
        end
    end

endmodule

// ----- rtl/early_drop_packet_queue.sv -----
// Byte-occupancy packet queue with linear random early drop.
// Input channel (s_valid/s_ready/s_data): one item is a packet arrival or a
// departure from the head. Result channel (m_valid/m_ready/m_data): exactly
// one result per item, in order, with the admit/drop decision, the popped
// size and the occupancy and drop totals after the item.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 is max_bytes, index 1 is drop_threshold, other indexes are ignored.
// Write it only while no item is in flight.
// An item passes through slot memory read, add/compare, 16x24 multiply,
// decision and write-back, in that order, and its result is registered. No new
// item is accepted until the current one has left the decision state.
// A new item is accepted while a finished result still waits at the output
// register; if the receiver stalls, the next item waits in its decision
// cycle until the output register frees.
// Reset empties the queue, zeroes the drop totals and loads the config
// defaults (65536 and 32768). The slot memory needs no clearing pass.
module early_drop_packet_queue
    import edpq_pkg::*;
#(
    parameter int SLOT_DEPTH = 64,
    parameter int RAND_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  edpq_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output edpq_out_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    localparam int PTR_W = $clog2(SLOT_DEPTH);
    localparam int CNT_W = $clog2(SLOT_DEPTH + 1);
    localparam int SMP_W = (RAND_BITS < SAMPLE_W) ? RAND_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((33'd1 << SMP_W) - 33'd1);
    localparam int CMP_W = BYTE_W + ((RAND_BITS > SAMPLE_W) ? RAND_BITS : SAMPLE_W);
    localparam int PROD_W = BYTE_W + SAMPLE_W;

    edpq_state_t state_reg, state_next;

    edpq_in_t          item_reg;
    logic [BYTE_W-1:0] max_bytes_reg;
    logic [BYTE_W-1:0] drop_thr_reg;
    logic [PTR_W-1:0]  head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]  tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0]  pkt_count_reg, pkt_count_next;
    logic [BYTE_W-1:0] byte_count_reg, byte_count_next;

    logic [SIZE_W-1:0] slot_mem [SLOT_DEPTH];
    logic [SIZE_W-1:0] rd_data_reg;
    logic              mem_we;

    logic              over_max_reg;
    logic              over_thr_reg;
    logic [BYTE_W-1:0] span_reg;
    logic [BYTE_W-1:0] excess_reg;
    logic [PROD_W-1:0] lhs_reg;
    logic [BYTE_W:0]   total;

    logic         m_valid_reg;
    edpq_out_t    m_data_reg, m_data_next;
    logic         out_free;
    logic         fire;
    logic         early;
    logic         slots_full;
    drop_cause_t  cause;
    drop_evt_t    drop_evt;
    drop_totals_t totals_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = (state_reg == ST_DEC) && out_free;

    assign total = {1'b0, byte_count_reg} + (BYTE_W+1)'(item_reg.pkt_size);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RST;
            drop_thr_reg  <= DROP_THR_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_BYTES:      max_bytes_reg <= cfg_data;
                CFG_DROP_THRESHOLD: drop_thr_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // slot FIFO storage: write at tail on admit, head read on accept
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[tail_ptr_reg] <= item_reg.pkt_size;
        end
        if (s_valid && s_ready) begin
            rd_data_reg <= slot_mem[head_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (state_reg == ST_CALC) begin
            over_max_reg <= total > {1'b0, max_bytes_reg};
            over_thr_reg <= total > {1'b0, drop_thr_reg};
            span_reg     <= max_bytes_reg - drop_thr_reg;
            excess_reg   <= BYTE_W'(total - {1'b0, drop_thr_reg});
        end
        if (state_reg == ST_MUL) begin
            lhs_reg <= PROD_W'(item_reg.rand_sample & SAMPLE_MASK) * PROD_W'(span_reg);
        end
    end

    assign early = over_thr_reg &&
                   (CMP_W'(lhs_reg) < CMP_W'({excess_reg, {RAND_BITS{1'b0}}}));
    assign slots_full = (pkt_count_reg >= CNT_W'(SLOT_DEPTH));

    always_comb begin
        if (over_max_reg) begin
            cause = CAUSE_BYTE_LIMIT;
        end else if (early) begin
            cause = CAUSE_EARLY;
        end else if (slots_full) begin
            cause = CAUSE_SLOTS_FULL;
        end else begin
            cause = CAUSE_NONE;
        end
    end

    always_comb begin
        state_next      = state_reg;
        head_ptr_next   = head_ptr_reg;
        tail_ptr_next   = tail_ptr_reg;
        pkt_count_next  = pkt_count_reg;
        byte_count_next = byte_count_reg;
        mem_we          = 1'b0;
        drop_evt.valid  = 1'b0;
        drop_evt.size   = item_reg.pkt_size;
        m_data_next     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DEC;
            ST_DEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (item_reg.req_type == REQ_ARRIVAL) begin
                        if (cause != CAUSE_NONE) begin
                            drop_evt.valid = 1'b1;
                        end else begin
                            mem_we          = 1'b1;
                            tail_ptr_next   = (tail_ptr_reg == PTR_W'(SLOT_DEPTH - 1)) ?
                                              '0 : tail_ptr_reg + 1'b1;
                            pkt_count_next  = pkt_count_reg + 1'b1;
                            byte_count_next = total[BYTE_W-1:0];
                            m_data_next.admitted = 1'b1;
                        end
                        m_data_next.drop_cause = cause;
                    end else if (pkt_count_reg == '0) begin
                        m_data_next.empty_error = 1'b1;
                    end else begin
                        head_ptr_next   = (head_ptr_reg == PTR_W'(SLOT_DEPTH - 1)) ?
                                          '0 : head_ptr_reg + 1'b1;
                        pkt_count_next  = pkt_count_reg - 1'b1;
                        byte_count_next = (byte_count_reg >= BYTE_W'(rd_data_reg)) ?
                                          byte_count_reg - BYTE_W'(rd_data_reg) : '0;
                        m_data_next.departed_valid = 1'b1;
                        m_data_next.departed_size  = rd_data_reg;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_data_next.occupancy_bytes     = byte_count_next;
        m_data_next.occupancy_pkts      = OCC_PKT_W'(pkt_count_next);
        m_data_next.total_dropped_pkts  = totals_next.pkts;
        m_data_next.total_dropped_bytes = totals_next.bytes;
    end

    edpq_drop_stats u_drop_stats (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .drop_evt    (drop_evt),
        .totals_next (totals_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_ptr_reg   <= '0;
            tail_ptr_reg   <= '0;
            pkt_count_reg  <= '0;
            byte_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_ptr_reg   <= head_ptr_next;
            tail_ptr_reg   <= tail_ptr_next;
            pkt_count_reg  <= pkt_count_next;
            byte_count_reg <= byte_count_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ----- rtl/edpq_checker.sv -----
`include "assert_macros.svh"

module edpq_props
    import edpq_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input edpq_out_t m_data
);

    logic admit_clean;
    logic depart_clean;

    assign admit_clean  = (m_data.drop_cause == CAUSE_NONE) && !m_data.departed_valid &&
                          !m_data.empty_error;
    assign depart_clean = !m_data.admitted && (m_data.drop_cause == CAUSE_NONE) &&
                          !m_data.empty_error;

    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_result_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_data))
    `ASSERT_NEXT(a_one_item_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ASSERT_IMPLIES(a_admit_clean, aclk, aresetn, m_valid && m_data.admitted, admit_clean)
    `ASSERT_IMPLIES(a_depart_clean, aclk, aresetn, m_valid && m_data.departed_valid, depart_clean)

endmodule

bind early_drop_packet_queue edpq_props u_edpq_props (.*);
